### hw/rtl/csc_pkg.sv
// Shared constants, command/state encodings and status struct for the chunk
// statistics compare block. No dependencies.
package csc_pkg;

  localparam int SAMPLE_BITS       = 24;
  localparam int FRAC_BITS         = 8;
  localparam int MAX_CHUNKS        = 1024;
  localparam int MAX_CHUNK_SAMPLES = 65536;

  localparam int CNT_W  = $clog2(MAX_CHUNK_SAMPLES + 1);   // sample count
  localparam int SUM_W  = SAMPLE_BITS + CNT_W - 1;          // signed running sum
  localparam int SQR_W  = 2 * SAMPLE_BITS;                  // one squared sample
  localparam int SQ_W   = 64;                               // sum of squares
  localparam int IDX_W  = $clog2(MAX_CHUNKS);               // store address
  localparam int CC_W   = $clog2(MAX_CHUNKS + 2);           // chunk counter
  localparam int NUM_W  = 10;                               // chunk_number field
  localparam int Q_W    = 32;                               // Q24.8 fields

  // iterative units
  localparam int MA_W   = SQ_W;                             // multiplicand
  localparam int MB_W   = SUM_W;                            // multiplier, one bit a step
  localparam int PROD_W = MA_W + MB_W;
  localparam int D_W    = 2 * SUM_W;                        // n*sumsq - sum^2
  localparam int DIV_W  = D_W + 2 * FRAC_BITS;              // dividend/quotient
  localparam int DVS_W  = 2 * CNT_W - 1;                    // divisor (up to n^2)
  localparam int SQI_W  = 64;                               // root input
  localparam int SQO_W  = SQI_W / 2;
  localparam int TOT_W  = 42;                               // difference totals
  localparam int IT_W   = $clog2(DIV_W);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_ACC, S_MEAN_LD, S_MEAN_DIV, S_MUL1_LD, S_MUL1, S_MUL2_LD,
    S_MUL2, S_MUL3_LD, S_MUL3, S_VAR_LD, S_VAR_DIV, S_SQRT_LD, S_SQRT, S_RD,
    S_BOOK, S_AVGM_LD, S_AVGM, S_AVGS_LD, S_AVGS, S_AVG_FIN, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CAPTURE, CMD_SQUARE, CMD_ACCUM, CMD_MEAN_START, CMD_DIV_STEP,
    CMD_MUL_NS_START, CMD_MUL_STEP, CMD_MUL_MM_START, CMD_MUL_NN_START,
    CMD_VAR_START, CMD_SQRT_START, CMD_SQRT_STEP, CMD_MEM_READ, CMD_BOOK,
    CMD_AVGM_START, CMD_AVGS_START, CMD_AVG_TAKE, CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic done;       // iterative unit on its final step
    logic lic;        // captured sample closes a chunk
    logic avg_go;     // final compared chunk with a nonzero chunk count
    logic out_busy;   // output register holds a transaction not yet taken
  } status_t;

endpackage

### hw/rtl/csc_ifs.sv
// Channel interfaces for the chunk statistics compare block.
// Depends on csc_pkg.
interface csc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 recording;
  logic signed [csc_pkg::SAMPLE_BITS-1:0] sample;
  logic                                 last_in_chunk;
  logic                                 last_chunk;
  modport source (output valid, recording, sample, last_in_chunk, last_chunk,
                  input ready);
  modport sink   (input valid, recording, sample, last_in_chunk, last_chunk,
                  output ready);
endinterface

interface csc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             out_recording;
  logic [csc_pkg::NUM_W-1:0]        chunk_number;
  logic signed [csc_pkg::Q_W-1:0]   chunk_mean;
  logic [csc_pkg::Q_W-1:0]          chunk_std_dev;
  logic                             compare_valid;
  logic [csc_pkg::Q_W-1:0]          mean_diff_avg;
  logic [csc_pkg::Q_W-1:0]          std_diff_avg;
  logic                             count_error;
  modport source (output valid, out_recording, chunk_number, chunk_mean, chunk_std_dev,
                  compare_valid, mean_diff_avg, std_diff_avg, count_error,
                  input ready);
  modport sink   (input valid, out_recording, chunk_number, chunk_mean, chunk_std_dev,
                  compare_valid, mean_diff_avg, std_diff_avg, count_error,
                  output ready);
endinterface

### hw/rtl/csc_ctrl.sv
// Sequencing state machine for the chunk statistics compare block.
// Depends on csc_pkg; drives commands into csc_datapath.
module csc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  csc_pkg::status_t st,
  output csc_pkg::cmd_t    cmd
);

  csc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csc_pkg::S_IDLE:     if (in_valid) state_nxt = csc_pkg::S_SQ;
      csc_pkg::S_SQ:       state_nxt = csc_pkg::S_ACC;
      csc_pkg::S_ACC:      state_nxt = st.lic ? csc_pkg::S_MEAN_LD : csc_pkg::S_IDLE;
      csc_pkg::S_MEAN_LD:  state_nxt = csc_pkg::S_MEAN_DIV;
      csc_pkg::S_MEAN_DIV: if (st.done) state_nxt = csc_pkg::S_MUL1_LD;
      csc_pkg::S_MUL1_LD:  state_nxt = csc_pkg::S_MUL1;
      csc_pkg::S_MUL1:     if (st.done) state_nxt = csc_pkg::S_MUL2_LD;
      csc_pkg::S_MUL2_LD:  state_nxt = csc_pkg::S_MUL2;
      csc_pkg::S_MUL2:     if (st.done) state_nxt = csc_pkg::S_MUL3_LD;
      csc_pkg::S_MUL3_LD:  state_nxt = csc_pkg::S_MUL3;
      csc_pkg::S_MUL3:     if (st.done) state_nxt = csc_pkg::S_VAR_LD;
      csc_pkg::S_VAR_LD:   state_nxt = csc_pkg::S_VAR_DIV;
      csc_pkg::S_VAR_DIV:  if (st.done) state_nxt = csc_pkg::S_SQRT_LD;
      csc_pkg::S_SQRT_LD:  state_nxt = csc_pkg::S_SQRT;
      csc_pkg::S_SQRT:     if (st.done) state_nxt = csc_pkg::S_RD;
      csc_pkg::S_RD:       state_nxt = csc_pkg::S_BOOK;
      csc_pkg::S_BOOK:     state_nxt = st.avg_go ? csc_pkg::S_AVGM_LD : csc_pkg::S_EMIT;
      csc_pkg::S_AVGM_LD:  state_nxt = csc_pkg::S_AVGM;
      csc_pkg::S_AVGM:     if (st.done) state_nxt = csc_pkg::S_AVGS_LD;
      csc_pkg::S_AVGS_LD:  state_nxt = csc_pkg::S_AVGS;
      csc_pkg::S_AVGS:     if (st.done) state_nxt = csc_pkg::S_AVG_FIN;
      csc_pkg::S_AVG_FIN:  state_nxt = csc_pkg::S_EMIT;
      csc_pkg::S_EMIT:     if (!st.out_busy) state_nxt = csc_pkg::S_IDLE;
      default:             state_nxt = csc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = csc_pkg::CMD_NONE;
    unique case (state_r)
      csc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = csc_pkg::CMD_CAPTURE;
      end
      csc_pkg::S_SQ:       cmd = csc_pkg::CMD_SQUARE;
      csc_pkg::S_ACC:      cmd = csc_pkg::CMD_ACCUM;
      csc_pkg::S_MEAN_LD:  cmd = csc_pkg::CMD_MEAN_START;
      csc_pkg::S_MEAN_DIV: cmd = csc_pkg::CMD_DIV_STEP;
      csc_pkg::S_MUL1_LD:  cmd = csc_pkg::CMD_MUL_NS_START;
      csc_pkg::S_MUL1:     cmd = csc_pkg::CMD_MUL_STEP;
      csc_pkg::S_MUL2_LD:  cmd = csc_pkg::CMD_MUL_MM_START;
      csc_pkg::S_MUL2:     cmd = csc_pkg::CMD_MUL_STEP;
      csc_pkg::S_MUL3_LD:  cmd = csc_pkg::CMD_MUL_NN_START;
      csc_pkg::S_MUL3:     cmd = csc_pkg::CMD_MUL_STEP;
      csc_pkg::S_VAR_LD:   cmd = csc_pkg::CMD_VAR_START;
      csc_pkg::S_VAR_DIV:  cmd = csc_pkg::CMD_DIV_STEP;
      csc_pkg::S_SQRT_LD:  cmd = csc_pkg::CMD_SQRT_START;
      csc_pkg::S_SQRT:     cmd = csc_pkg::CMD_SQRT_STEP;
      csc_pkg::S_RD:       cmd = csc_pkg::CMD_MEM_READ;
      csc_pkg::S_BOOK:     cmd = csc_pkg::CMD_BOOK;
      csc_pkg::S_AVGM_LD:  cmd = csc_pkg::CMD_AVGM_START;
      csc_pkg::S_AVGM:     cmd = csc_pkg::CMD_DIV_STEP;
      csc_pkg::S_AVGS_LD:  cmd = csc_pkg::CMD_AVGS_START;
      csc_pkg::S_AVGS:     cmd = csc_pkg::CMD_DIV_STEP;
      csc_pkg::S_AVG_FIN:  cmd = csc_pkg::CMD_AVG_TAKE;
      csc_pkg::S_EMIT:     if (!st.out_busy) cmd = csc_pkg::CMD_EMIT;
      default:             cmd = csc_pkg::CMD_NONE;
    endcase
  end

endmodule

### hw/rtl/csc_datapath.sv
// Accumulators, shift-add multiplier, restoring divider, square root unit,
// chunk stats store and output register. Depends on csc_pkg.
module csc_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  csc_pkg::cmd_t                           cmd,
  output csc_pkg::status_t                        st,
  input  logic                                    in_recording,
  input  logic signed [csc_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  logic                                    in_last_in_chunk,
  input  logic                                    in_last_chunk,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic                                    out_recording,
  output logic [csc_pkg::NUM_W-1:0]               out_chunk_number,
  output logic signed [csc_pkg::Q_W-1:0]          out_chunk_mean,
  output logic [csc_pkg::Q_W-1:0]                 out_chunk_std_dev,
  output logic                                    out_compare_valid,
  output logic [csc_pkg::Q_W-1:0]                 out_mean_diff_avg,
  output logic [csc_pkg::Q_W-1:0]                 out_std_diff_avg,
  output logic                                    out_count_error
);

  localparam int SB = csc_pkg::SAMPLE_BITS;
  localparam int QW = csc_pkg::Q_W;

  // captured transaction
  logic                    rec_r, lic_r, lc_r;
  logic signed [SB-1:0]    smp_r;
  logic [csc_pkg::SQR_W-1:0] sqp_r;

  // chunk accumulators
  logic signed [csc_pkg::SUM_W-1:0] sum_r;
  logic [csc_pkg::SQ_W-1:0]         sq_r;
  logic [csc_pkg::CNT_W-1:0]        cnt_r;

  // iterative units
  logic [csc_pkg::IT_W-1:0]   iter_r;
  logic [csc_pkg::MA_W-1:0]   mpa_r;
  logic [csc_pkg::MB_W-1:0]   mpb_r;
  logic [csc_pkg::PROD_W-1:0] prod_r;
  logic [csc_pkg::D_W-1:0]    t1_r, d_r;
  logic [csc_pkg::DIV_W-1:0]  dq_r;
  logic [csc_pkg::DVS_W-1:0]  dvs_r, rem_r;
  logic [csc_pkg::SQI_W-1:0]  sv_r;
  logic [csc_pkg::SQO_W+1:0]  srem_r;
  logic [csc_pkg::SQO_W-1:0]  sroot_r;
  logic                       std_sat_r;

  // chunk results and bookkeeping
  logic [QW-1:0]              mean_r, std_r, mavg_r, savg_r;
  logic [2*QW-1:0]            rd_r;
  logic [csc_pkg::CC_W-1:0]   cc_r, ref_r, m_r;
  logic [csc_pkg::CC_W-1:0]   idx_r;
  logic                       err_r, cerr_r, cval_r;
  logic [csc_pkg::TOT_W-1:0]  mtot_r, stot_r;

  logic [2*QW-1:0] store_mem [csc_pkg::MAX_CHUNKS];

  // output register
  logic                    ov_r, orec_r, ocval_r, ocerr_r;
  logic [csc_pkg::NUM_W-1:0] onum_r;
  logic [QW-1:0]           omean_r, ostd_r, omavg_r, osavg_r;

  // ---- combinational helpers ----
  logic [SB-1:0]                 smag;
  logic [csc_pkg::SUM_W-1:0]     sum_mag;
  logic [csc_pkg::MA_W:0]        mul_hi;
  logic [csc_pkg::DVS_W:0]       div_sh, div_diff;
  logic [csc_pkg::SQO_W+3:0]     sq_sh, sq_trial;
  logic [QW-1:0]                 mean_q, dq_sat;
  logic [csc_pkg::D_W-1:0]       mm_prod;
  logic [csc_pkg::CC_W-1:0]      cc_inc, m_min, m_calc;
  logic                          in_range, err0, pair_ok;
  logic [QW:0]                   dm, dm_abs;
  logic [QW-1:0]                 sdiff, rd_mean, rd_std;
  logic                          store_we;

  always_comb begin
    smag     = smp_r[SB-1] ? SB'(-smp_r) : SB'(smp_r);
    sum_mag  = sum_r[csc_pkg::SUM_W-1] ? csc_pkg::SUM_W'(-sum_r) : csc_pkg::SUM_W'(sum_r);
    mul_hi   = {1'b0, prod_r[csc_pkg::PROD_W-1:csc_pkg::MB_W]}
             + (mpb_r[0] ? {1'b0, mpa_r} : '0);
    div_sh   = {rem_r, dq_r[csc_pkg::DIV_W-1]};
    div_diff = div_sh - {1'b0, dvs_r};
    sq_sh    = {srem_r, sv_r[csc_pkg::SQI_W-1 -: 2]};
    sq_trial = {2'b00, sroot_r, 2'b01};
    mm_prod  = prod_r[csc_pkg::D_W-1:0];
    dq_sat   = (|dq_r[csc_pkg::DIV_W-1:QW]) ? '1 : dq_r[QW-1:0];
    // mean: round half away from zero, saturate to the signed range
    if (sum_r[csc_pkg::SUM_W-1]) begin
      if ((|dq_r[csc_pkg::DIV_W-1:QW]) || (dq_r[QW-1:0] > {1'b1, {(QW-1){1'b0}}})) begin
        mean_q = {1'b1, {(QW-1){1'b0}}};
      end else begin
        mean_q = QW'(-dq_r[QW-1:0]);
      end
    end else begin
      mean_q = (|dq_r[csc_pkg::DIV_W-1:QW-1]) ? {1'b0, {(QW-1){1'b1}}} : dq_r[QW-1:0];
    end
    // chunk bookkeeping
    cc_inc   = (cc_r <= csc_pkg::CC_W'(csc_pkg::MAX_CHUNKS)) ? cc_r + 1'b1 : cc_r;
    in_range = cc_r < csc_pkg::CC_W'(csc_pkg::MAX_CHUNKS);
    err0     = (cc_r == '0) ? 1'b0 : err_r;
    pair_ok  = in_range && (cc_r < ref_r);
    m_min    = (ref_r < cc_inc) ? ref_r : cc_inc;
    m_calc   = (m_min > csc_pkg::CC_W'(csc_pkg::MAX_CHUNKS))
             ? csc_pkg::CC_W'(csc_pkg::MAX_CHUNKS) : m_min;
    rd_mean  = rd_r[2*QW-1:QW];
    rd_std   = rd_r[QW-1:0];
    dm       = {mean_r[QW-1], mean_r} - {rd_mean[QW-1], rd_mean};
    dm_abs   = dm[QW] ? (QW+1)'(-dm) : dm;
    sdiff    = (std_r > rd_std) ? std_r - rd_std : rd_std - std_r;
    store_we = (cmd == csc_pkg::CMD_BOOK) && !rec_r && in_range;
  end

  assign st.done     = (iter_r == '0);
  assign st.lic      = lic_r;
  assign st.avg_go   = rec_r && lc_r && (m_calc != '0);
  assign st.out_busy = ov_r && !out_ready;

  // chunk stats store: one write port, registered read
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[cc_r[csc_pkg::IDX_W-1:0]] <= {mean_r, std_r};
    end
    if (cmd == csc_pkg::CMD_MEM_READ) begin
      rd_r <= store_mem[cc_r[csc_pkg::IDX_W-1:0]];
    end
  end

  // payload and unit registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      csc_pkg::CMD_CAPTURE: begin
        rec_r <= in_recording;
        smp_r <= in_sample;
        lic_r <= in_last_in_chunk;
        lc_r  <= in_last_chunk;
      end
      csc_pkg::CMD_SQUARE: sqp_r <= smag * smag;
      csc_pkg::CMD_MEAN_START: begin
        dq_r   <= csc_pkg::DIV_W'({sum_mag, {csc_pkg::FRAC_BITS{1'b0}}})
                + csc_pkg::DIV_W'(cnt_r >> 1);
        dvs_r  <= csc_pkg::DVS_W'(cnt_r);
        rem_r  <= '0;
        iter_r <= csc_pkg::IT_W'(csc_pkg::DIV_W - 1);
      end
      csc_pkg::CMD_DIV_STEP: begin
        if (!div_diff[csc_pkg::DVS_W]) begin
          rem_r <= div_diff[csc_pkg::DVS_W-1:0];
          dq_r  <= {dq_r[csc_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= div_sh[csc_pkg::DVS_W-1:0];
          dq_r  <= {dq_r[csc_pkg::DIV_W-2:0], 1'b0};
        end
        if (iter_r != '0) iter_r <= iter_r - 1'b1;
      end
      csc_pkg::CMD_MUL_NS_START: begin
        mean_r <= mean_q;
        mpa_r  <= sq_r;
        mpb_r  <= csc_pkg::MB_W'(cnt_r);
        prod_r <= '0;
        iter_r <= csc_pkg::IT_W'(csc_pkg::MB_W - 1);
      end
      csc_pkg::CMD_MUL_STEP: begin
        prod_r <= {mul_hi, prod_r[csc_pkg::MB_W-1:1]};
        mpb_r  <= mpb_r >> 1;
        if (iter_r != '0) iter_r <= iter_r - 1'b1;
      end
      csc_pkg::CMD_MUL_MM_START: begin
        t1_r   <= prod_r[csc_pkg::D_W-1:0];
        mpa_r  <= csc_pkg::MA_W'(sum_mag);
        mpb_r  <= sum_mag;
        prod_r <= '0;
        iter_r <= csc_pkg::IT_W'(csc_pkg::MB_W - 1);
      end
      csc_pkg::CMD_MUL_NN_START: begin
        // a negative difference can only come from wrap: take it as zero
        d_r    <= (t1_r >= mm_prod) ? t1_r - mm_prod : '0;
        mpa_r  <= csc_pkg::MA_W'(cnt_r);
        mpb_r  <= csc_pkg::MB_W'(cnt_r);
        prod_r <= '0;
        iter_r <= csc_pkg::IT_W'(csc_pkg::MB_W - 1);
      end
      csc_pkg::CMD_VAR_START: begin
        dq_r   <= {d_r, {(2*csc_pkg::FRAC_BITS){1'b0}}};
        dvs_r  <= prod_r[csc_pkg::DVS_W-1:0];
        rem_r  <= '0;
        iter_r <= csc_pkg::IT_W'(csc_pkg::DIV_W - 1);
      end
      csc_pkg::CMD_SQRT_START: begin
        std_sat_r <= |dq_r[csc_pkg::DIV_W-1:csc_pkg::SQI_W];
        sv_r      <= dq_r[csc_pkg::SQI_W-1:0];
        srem_r    <= '0;
        sroot_r   <= '0;
        iter_r    <= csc_pkg::IT_W'(csc_pkg::SQO_W - 1);
      end
      csc_pkg::CMD_SQRT_STEP: begin
        if (sq_sh >= sq_trial) begin
          srem_r  <= (csc_pkg::SQO_W+2)'(sq_sh - sq_trial);
          sroot_r <= {sroot_r[csc_pkg::SQO_W-2:0], 1'b1};
        end else begin
          srem_r  <= (csc_pkg::SQO_W+2)'(sq_sh);
          sroot_r <= {sroot_r[csc_pkg::SQO_W-2:0], 1'b0};
        end
        sv_r <= {sv_r[csc_pkg::SQI_W-3:0], 2'b00};
        if (iter_r != '0) iter_r <= iter_r - 1'b1;
      end
      csc_pkg::CMD_MEM_READ: begin
        std_r <= std_sat_r ? '1 : QW'(sroot_r);
        idx_r <= cc_r;
      end
      csc_pkg::CMD_BOOK: begin
        m_r    <= m_calc;
        mavg_r <= '0;
        savg_r <= '0;
      end
      csc_pkg::CMD_AVGM_START: begin
        dq_r   <= csc_pkg::DIV_W'(mtot_r) + csc_pkg::DIV_W'(m_r >> 1);
        dvs_r  <= csc_pkg::DVS_W'(m_r);
        rem_r  <= '0;
        iter_r <= csc_pkg::IT_W'(csc_pkg::DIV_W - 1);
      end
      csc_pkg::CMD_AVGS_START: begin
        mavg_r <= dq_sat;
        dq_r   <= csc_pkg::DIV_W'(stot_r) + csc_pkg::DIV_W'(m_r >> 1);
        dvs_r  <= csc_pkg::DVS_W'(m_r);
        rem_r  <= '0;
        iter_r <= csc_pkg::IT_W'(csc_pkg::DIV_W - 1);
      end
      csc_pkg::CMD_AVG_TAKE: savg_r <= dq_sat;
      default: ;
    endcase
  end

  // control state: accumulators, counters, flags, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      sq_r   <= '0;
      cnt_r  <= '0;
      cc_r   <= '0;
      ref_r  <= '0;
      err_r  <= 1'b0;
      cerr_r <= 1'b0;
      cval_r <= 1'b0;
      mtot_r <= '0;
      stot_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (ov_r && out_ready && (cmd != csc_pkg::CMD_EMIT)) ov_r <= 1'b0;
      unique case (cmd)
        csc_pkg::CMD_ACCUM: begin
          // a full chunk leaves further samples out of the sums
          if (cnt_r < csc_pkg::CNT_W'(csc_pkg::MAX_CHUNK_SAMPLES)) begin
            sum_r <= sum_r + csc_pkg::SUM_W'(smp_r);
            sq_r  <= sq_r + csc_pkg::SQ_W'(sqp_r);
            cnt_r <= cnt_r + 1'b1;
          end
        end
        csc_pkg::CMD_MEM_READ: begin
          sum_r <= '0;
          sq_r  <= '0;
          cnt_r <= '0;
        end
        csc_pkg::CMD_BOOK: begin
          if (!rec_r) begin
            cerr_r <= in_range ? err0 : 1'b1;
            err_r  <= in_range ? err0 : 1'b1;
            cval_r <= 1'b0;
            if (lc_r) begin
              ref_r  <= cc_inc;
              cc_r   <= '0;
              mtot_r <= '0;
              stot_r <= '0;
            end else begin
              cc_r <= cc_inc;
            end
          end else begin
            if (pair_ok) begin
              mtot_r <= mtot_r + csc_pkg::TOT_W'(dm_abs);
              stot_r <= stot_r + csc_pkg::TOT_W'(sdiff);
            end
            if (lc_r) begin
              cval_r <= 1'b1;
              cerr_r <= !pair_ok || err0 || (cc_inc != ref_r)
                     || (ref_r > csc_pkg::CC_W'(csc_pkg::MAX_CHUNKS)) || (m_calc == '0);
              cc_r   <= '0;
              err_r  <= 1'b0;
              if (m_calc == '0) begin
                mtot_r <= '0;
                stot_r <= '0;
              end
            end else begin
              cval_r <= 1'b0;
              cerr_r <= pair_ok ? err0 : 1'b1;
              err_r  <= pair_ok ? err0 : 1'b1;
              cc_r   <= cc_inc;
            end
          end
        end
        csc_pkg::CMD_AVG_TAKE: begin
          mtot_r <= '0;
          stot_r <= '0;
        end
        csc_pkg::CMD_EMIT: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == csc_pkg::CMD_EMIT) begin
      orec_r  <= rec_r;
      onum_r  <= idx_r[csc_pkg::NUM_W-1:0];
      omean_r <= mean_r;
      ostd_r  <= std_r;
      ocval_r <= cval_r;
      omavg_r <= mavg_r;
      osavg_r <= savg_r;
      ocerr_r <= cerr_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_recording     = orec_r;
  assign out_chunk_number  = onum_r;
  assign out_chunk_mean    = omean_r;
  assign out_chunk_std_dev = ostd_r;
  assign out_compare_valid = ocval_r;
  assign out_mean_diff_avg = omavg_r;
  assign out_std_diff_avg  = osavg_r;
  assign out_count_error   = ocerr_r;

endmodule

### hw/rtl/chunk_stats_compare_unit.sv
// Chunk statistics compare block: per-chunk mean and standard deviation of two
// recordings with comparison against the stored reference. Every sample passes
// through accept, square and accumulate states. A closing sample adds chunk-end
// work in the one-bit-a-step divider (two 96-step divisions), the shift-add
// multiplier (three 40-step products) and the 32-step square root; the final
// chunk of the compared recording, with a nonzero chunk count, adds two further
// 96-step divisions for the averages. One item is in work at a time; the finished
// transaction sits in an output register so the next sample is taken while it waits.
// Depends on csc_pkg, csc_ifs, csc_ctrl and csc_datapath.
module chunk_stats_compare_unit (
  input  logic        clk,
  input  logic        rst_n,
  csc_in_if.sink      in_ch,
  csc_out_if.source   out_ch
);

  csc_pkg::cmd_t    cmd;
  csc_pkg::status_t st;

  csc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  csc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_recording      (in_ch.recording),
    .in_sample         (in_ch.sample),
    .in_last_in_chunk  (in_ch.last_in_chunk),
    .in_last_chunk     (in_ch.last_chunk),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_recording     (out_ch.out_recording),
    .out_chunk_number  (out_ch.chunk_number),
    .out_chunk_mean    (out_ch.chunk_mean),
    .out_chunk_std_dev (out_ch.chunk_std_dev),
    .out_compare_valid (out_ch.compare_valid),
    .out_mean_diff_avg (out_ch.mean_diff_avg),
    .out_std_diff_avg  (out_ch.std_diff_avg),
    .out_count_error   (out_ch.count_error)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for chunk_stats_compare_unit: drives sample streams of two
// recordings and checks every chunk transaction against an in-bench predictor.
// Depends on csc_pkg, csc_ifs and the block's RTL.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int unsigned RANDOM_ITEMS = 450;

  typedef struct packed {
    logic        recording;
    logic [9:0]  chunk_number;
    logic [31:0] chunk_mean;
    logic [31:0] chunk_std_dev;
    logic        compare_valid;
    logic [31:0] mean_diff_avg;
    logic [31:0] std_diff_avg;
    logic        count_error;
  } chunk_result_t;

  logic clk;
  logic rst_n;
  csc_in_if  in_ch();
  csc_out_if out_ch();

  chunk_stats_compare_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [63:0] run_sum;
  logic [63:0] run_sq;
  int unsigned run_n;
  int unsigned chunk_idx;
  int unsigned ref_chunks;
  logic [31:0] ref_mean[csc_pkg::MAX_CHUNKS];
  logic [31:0] ref_std[csc_pkg::MAX_CHUNKS];
  logic [63:0] mean_diff_sum;
  logic [63:0] std_diff_sum;
  bit          chunk_err;

  chunk_result_t expected_chunks[$];
  int unsigned   items_sent;
  int unsigned   cycles;
  int unsigned   fail_count;
  bit            idle_on;
  int unsigned   stall_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d chunk transactions still awaited", $time,
               expected_chunks.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (64'(t) * 64'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] abs_diff32(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // works out the transaction (if any) caused by one accepted sample
  function automatic void predict_chunk(input bit rec, input logic signed [23:0] smp,
                                        input bit lic, input bit lc,
                                        output bit got, output chunk_result_t r);
    logic [63:0]  s64;
    logic [63:0]  mag;
    logic [127:0] n;
    logic [127:0] m;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] d;
    logic [127:0] v;
    logic [31:0]  mean_q;
    logic [31:0]  std_q;
    logic [63:0]  dm;
    logic [63:0]  cnt;
    int unsigned  idx;
    bit           neg;
    s64 = {{40{smp[23]}}, smp};
    got = 1'b0;
    r = '0;
    if (run_n < csc_pkg::MAX_CHUNK_SAMPLES) begin
      mag = s64[63] ? -s64 : s64;
      run_sum += s64;
      run_sq += mag * mag;
      run_n++;
    end
    if (!lic) return;
    got = 1'b1;
    n = 128'(run_n);
    neg = run_sum[63];
    mag = neg ? -run_sum : run_sum;
    m = ((128'(mag) << csc_pkg::FRAC_BITS) + n / 2) / n;
    if (neg) mean_q = (m > 128'h8000_0000) ? 32'h8000_0000 : -m[31:0];
    else mean_q = (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    a = n * 128'(run_sq);
    b = 128'(mag) * 128'(mag);
    d = (a < b) ? '0 : a - b;
    v = (d << (2 * csc_pkg::FRAC_BITS)) / (n * n);
    std_q = (v[127:64] != 0) ? 32'hFFFF_FFFF : floor_root(v[63:0]);
    run_sum = '0;
    run_sq = '0;
    run_n = 0;
    if (chunk_idx == 0) chunk_err = 1'b0;
    idx = chunk_idx;
    if (chunk_idx <= csc_pkg::MAX_CHUNKS) chunk_idx++;
    r.recording = rec;
    r.chunk_number = idx[9:0];
    r.chunk_mean = mean_q;
    r.chunk_std_dev = std_q;
    if (!rec) begin
      if (idx < csc_pkg::MAX_CHUNKS) begin
        ref_mean[idx] = mean_q;
        ref_std[idx] = std_q;
      end else chunk_err = 1'b1;
      if (lc) begin
        ref_chunks = chunk_idx;
        chunk_idx = 0;
        mean_diff_sum = '0;
        std_diff_sum = '0;
      end
      r.count_error = chunk_err;
    end else begin
      if (idx < ref_chunks && idx < csc_pkg::MAX_CHUNKS) begin
        dm = 64'(signed'(mean_q)) - 64'(signed'(ref_mean[idx]));
        mean_diff_sum += dm[63] ? -dm : dm;
        std_diff_sum += 64'(abs_diff32(std_q, ref_std[idx]));
      end else chunk_err = 1'b1;
      r.count_error = chunk_err;
      if (lc) begin
        cnt = (ref_chunks < chunk_idx) ? 64'(ref_chunks) : 64'(chunk_idx);
        if (cnt > 64'(csc_pkg::MAX_CHUNKS)) cnt = 64'(csc_pkg::MAX_CHUNKS);
        r.compare_valid = 1'b1;
        if (chunk_idx != ref_chunks || ref_chunks > csc_pkg::MAX_CHUNKS || cnt == 0)
          r.count_error = 1'b1;
        if (cnt != 0) begin
          dm = (mean_diff_sum + cnt / 2) / cnt;
          r.mean_diff_avg = (dm > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dm[31:0];
          dm = (std_diff_sum + cnt / 2) / cnt;
          r.std_diff_avg = (dm > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dm[31:0];
        end
        chunk_idx = 0;
        mean_diff_sum = '0;
        std_diff_sum = '0;
        chunk_err = 1'b0;
      end
    end
  endfunction

  // result side: random stall bursts while idle_on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    chunk_result_t got_r;
    chunk_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_r = {out_ch.out_recording, out_ch.chunk_number, out_ch.chunk_mean,
               out_ch.chunk_std_dev, out_ch.compare_valid, out_ch.mean_diff_avg,
               out_ch.std_diff_avg, out_ch.count_error};
      if (expected_chunks.size() == 0) begin
        fail_count++;
        $display("%0t unexpected transaction: actual %p", $time, got_r);
      end else begin
        exp_r = expected_chunks.pop_front();
        if (got_r !== exp_r) begin
          fail_count++;
          $display("%0t chunk mismatch: expected %p actual %p", $time, exp_r, got_r);
        end
      end
    end
  end

  task automatic send_sample(input bit rec, input logic signed [23:0] smp,
                             input bit lic, input bit lc);
    bit got;
    chunk_result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.recording = rec;
    in_ch.sample = smp;
    in_ch.last_in_chunk = lic;
    in_ch.last_chunk = lc;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_chunk(rec, smp, lic, lc, got, r);
    if (got) expected_chunks.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2, 3: return 24'($urandom);
      default: return 24'($urandom_range(0, 400)) - 24'sd200;
    endcase
  endfunction

  // one chunk; non-closing samples carry random recording and stray last_chunk marks
  task automatic send_chunk(input bit rec, input int unsigned len, input bit lc);
    for (int unsigned i = 1; i < len; i++)
      send_sample(1'($urandom_range(0, 1)), pick_sample(), 1'b0,
                  $urandom_range(0, 9) == 0);
    send_sample(rec, pick_sample(), 1'b1, lc);
  endtask

  task automatic send_recording(input bit rec, input int unsigned chunks,
                                input int unsigned max_len);
    for (int unsigned c = 1; c <= chunks; c++)
      send_chunk(rec, $urandom_range(1, max_len), c == chunks);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_chunks.size() != 0) @(negedge clk);
  endtask

  // no reference yet: averages are zero and the count is flagged
  task automatic test_no_reference();
    send_recording(1'b1, 2, 3);
  endtask

  task automatic test_extremes();
    send_sample(1'b0, 24'sh7FFFFF, 1'b1, 1'b0);
    send_sample(1'b0, 24'sh800000, 1'b0, 1'b0);
    send_sample(1'b0, 24'sh7FFFFF, 1'b1, 1'b0);
    send_sample(1'b0, 24'sh800000, 1'b0, 1'b0);
    send_sample(1'b0, 24'sh800000, 1'b1, 1'b1);
    send_sample(1'b1, 24'sh800000, 1'b1, 1'b0);
    send_sample(1'b1, 24'sh000000, 1'b0, 1'b0);
    send_sample(1'b1, 24'sh7FFFFF, 1'b1, 1'b0);
    send_sample(1'b1, 24'sh000001, 1'b0, 1'b1);    // stray last_chunk
    send_sample(1'b1, 24'shFFFFFF, 1'b1, 1'b1);
  endtask

  // compared recording longer and shorter than the reference
  task automatic test_count_mismatch();
    send_recording(1'b0, 2, 3);
    send_recording(1'b1, 3, 3);
    send_recording(1'b0, 3, 2);
    send_recording(1'b1, 2, 2);
  endtask

  // reference overflows the store and the chunk counter saturates
  task automatic test_store_overflow();
    send_recording(1'b0, csc_pkg::MAX_CHUNKS + 2, 1);
    send_recording(1'b1, 2, 2);
  endtask

  task automatic test_random();
    int unsigned start;
    int unsigned k;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start > RANDOM_ITEMS * 3 / 4) idle_on = 1'b0;
      k = $urandom_range(1, 4);
      case ($urandom_range(0, 9))
        7: send_recording(1'b1, k, 6);
        8: send_recording(1'b0, k, 6);
        9: begin
          send_recording(1'b0, k, 6);
          send_recording(1'b1, $urandom_range(1, 5), 6);
        end
        default: begin
          send_recording(1'b0, k, ($urandom_range(0, 7) == 0) ? 40 : 6);
          send_recording(1'b1, k, ($urandom_range(0, 7) == 0) ? 40 : 6);
        end
      endcase
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.recording = 1'b0;
    in_ch.sample = '0;
    in_ch.last_in_chunk = 1'b0;
    in_ch.last_chunk = 1'b0;
    out_ch.ready = 1'b0;
    stall_left = 0;
    idle_on = 1'b1;
    run_sum = '0;
    run_sq = '0;
    run_n = 0;
    chunk_idx = 0;
    ref_chunks = 0;
    mean_diff_sum = '0;
    std_diff_sum = '0;
    chunk_err = 1'b0;
    for (int i = 0; i < csc_pkg::MAX_CHUNKS; i++) begin
      ref_mean[i] = '0;
      ref_std[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_no_reference();
    test_extremes();
    test_count_mismatch();
    wait_drained();
    test_store_overflow();
    test_random();

    wait_drained();
    repeat (1000) @(posedge clk);
    if (fail_count == 0 && expected_chunks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0t %0d failures, %0d chunk transactions never arrived", $time,
               fail_count, expected_chunks.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
